FILE: design/kvz_pkg.sv
`timescale 1ns / 1ps

package kvz_pkg;

    localparam logic [1:0] REQ_PRESET = 2'd0;
    localparam logic [1:0] REQ_ZONE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic CFG_ZONE_TOTAL  = 1'b0;
    localparam logic CFG_MAX_MATCHES = 1'b1;

    localparam int unsigned DRUM_BANK = 128;
    localparam int unsigned PROG_MAX  = 127;

    typedef struct packed {
        logic [10:0] zone_span;
        logic [9:0]  first_zone;
    } t_preset;

    typedef struct packed {
        logic [6:0] vel_high;
        logic [6:0] vel_low;
        logic [6:0] key_high;
        logic [6:0] key_low;
    } t_zone;

endpackage

FILE: design/kvz_req_if.sv
`timescale 1ns / 1ps

interface kvz_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  entry_index;
    logic [9:0]  first_zone;
    logic [10:0] zone_span;
    logic [6:0]  key_low;
    logic [6:0]  key_high;
    logic [6:0]  vel_low;
    logic [6:0]  vel_high;
    logic [13:0] bank_number;
    logic [7:0]  program_number;
    logic [6:0]  note_key;
    logic [6:0]  note_velocity;

    modport source (
        output valid, req_type, entry_index, first_zone, zone_span, key_low, key_high,
               vel_low, vel_high, bank_number, program_number, note_key, note_velocity,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, first_zone, zone_span, key_low, key_high,
               vel_low, vel_high, bank_number, program_number, note_key, note_velocity,
        output ready
    );
endinterface

FILE: design/kvz_rsp_if.sv
`timescale 1ns / 1ps

interface kvz_rsp_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [9:0] zone_index;
    logic [5:0] match_number;
    logic       last;

    modport source (
        output valid, matched, zone_index, match_number, last,
        input  ready
    );

    modport sink (
        input  valid, matched, zone_index, match_number, last,
        output ready
    );
endinterface

FILE: design/kvz_ram.sv
`timescale 1ns / 1ps

module kvz_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/kvz_match.sv
`timescale 1ns / 1ps

module kvz_match (
    input  kvz_pkg::t_zone i_zone,
    input  logic [6:0]     i_key,
    input  logic [6:0]     i_vel,
    output logic           o_hit
);

    always_comb begin
        o_hit = (i_key >= i_zone.key_low) && (i_key <= i_zone.key_high) &&
                (i_vel >= i_zone.vel_low) && (i_vel <= i_zone.vel_high);
    end

endmodule

FILE: design/key_velocity_zone_lookup.sv
`timescale 1ns / 1ps

// Key/velocity zone lookup.
// i_req carries write and lookup transactions, o_rsp carries results; both
// move on valid and ready high at a rising edge. i_cfg_* writes zone_total
// (index 0) and max_matches (index 1); the user must write them only while
// the block is idle, which the block does not enforce. A preset or zone
// write, an unused request type and an invalid lookup are each acknowledged
// by one result (matched 0, last 1). A lookup reads its preset entry, then
// walks its zones through one range comparator, each zone through a check
// state that reads zone memory and a compare state. Each matching zone, up
// to the match limit, gives one result, the final one marked last, or one
// unmatched result if none match. i_req.ready is high only between
// transactions, so one item is in work at a time; the next is taken while
// the final result still waits. A stalled receiver holds the walk at the
// next match until the output register drains. Reset (synchronous, active
// low) empties the block and sets zone_total to 0 and max_matches to 64;
// table contents are undefined until written and need no clearing pass.

module key_velocity_zone_lookup #(
    parameter int PRESET_COUNT    = 256,
    parameter int ZONE_DEPTH      = 1024,
    parameter int MAX_MATCH_LIMIT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [10:0]       i_cfg_wdata,
    kvz_req_if.sink           i_req,
    kvz_rsp_if.source         o_rsp
);

    localparam int PA = $clog2(PRESET_COUNT);
    localparam int ZA = (ZONE_DEPTH > 1) ? $clog2(ZONE_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PRESET  = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_COMPARE = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [10:0] r_zone_total;
    logic [6:0]  r_max_matches;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_key, n_key;
    logic [6:0]  r_vel, n_vel;
    logic [6:0]  r_limit, n_limit;
    logic [10:0] r_zi, n_zi;
    logic [10:0] r_left, n_left;
    logic [6:0]  r_found, n_found;
    logic        r_pend_v, n_pend_v;
    logic [9:0]  r_pend_zi, n_pend_zi;
    logic [5:0]  r_pend_num, n_pend_num;

    logic        r_ov, n_ov;
    logic        r_o_matched, n_o_matched;
    logic [9:0]  r_o_zone, n_o_zone;
    logic [5:0]  r_o_num, n_o_num;
    logic        r_o_last, n_o_last;

    logic             preset_we;
    logic             zone_we;
    logic [7:0]       lookup_idx;
    logic             lookup_ok;
    logic [6:0]       limit_in;
    logic             out_free;
    logic             walk_end;
    logic             hit;
    kvz_pkg::t_preset preset_wdata;
    kvz_pkg::t_preset preset_rdata;
    kvz_pkg::t_zone   zone_wdata;
    kvz_pkg::t_zone   zone_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_total  <= '0;
            r_max_matches <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == kvz_pkg::CFG_ZONE_TOTAL) begin
                r_zone_total <= i_cfg_wdata;
            end else begin
                r_max_matches <= i_cfg_wdata[6:0];
            end
        end
    end

    assign preset_wdata = '{zone_span: i_req.zone_span, first_zone: i_req.first_zone};
    assign zone_wdata   = '{vel_high: i_req.vel_high, vel_low: i_req.vel_low,
                            key_high: i_req.key_high, key_low: i_req.key_low};

    always_comb begin
        lookup_idx = {(i_req.bank_number == 14'(kvz_pkg::DRUM_BANK)),
                      i_req.program_number[6:0]};
        limit_in   = (r_max_matches > 7'(MAX_MATCH_LIMIT)) ? 7'(MAX_MATCH_LIMIT)
                                                           : r_max_matches;
        lookup_ok  = (r_zone_total != '0) &&
                     (i_req.program_number <= 8'(kvz_pkg::PROG_MAX)) &&
                     ({1'b0, lookup_idx} < 9'(PRESET_COUNT)) &&
                     (limit_in != '0);
        out_free   = !r_ov || o_rsp.ready;
        walk_end   = (r_left == '0) || (r_found == r_limit) ||
                     (r_zi >= r_zone_total) || ({6'b0, r_zi} >= 17'(ZONE_DEPTH));
    end

    kvz_ram #(
        .WIDTH ($bits(kvz_pkg::t_preset)),
        .DEPTH (PRESET_COUNT)
    ) u_preset_ram (
        .i_clk   (i_clk),
        .i_we    (preset_we),
        .i_waddr (PA'(i_req.entry_index)),
        .i_wdata (preset_wdata),
        .i_raddr (PA'(lookup_idx)),
        .o_rdata (preset_rdata)
    );

    kvz_ram #(
        .WIDTH ($bits(kvz_pkg::t_zone)),
        .DEPTH (ZONE_DEPTH)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (zone_we),
        .i_waddr (ZA'(i_req.entry_index)),
        .i_wdata (zone_wdata),
        .i_raddr (ZA'(r_zi)),
        .o_rdata (zone_rdata)
    );

    kvz_match u_match (
        .i_zone (zone_rdata),
        .i_key  (r_key),
        .i_vel  (r_vel),
        .o_hit  (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_vel       = r_vel;
        n_limit     = r_limit;
        n_zi        = r_zi;
        n_left      = r_left;
        n_found     = r_found;
        n_pend_v    = r_pend_v;
        n_pend_zi   = r_pend_zi;
        n_pend_num  = r_pend_num;
        n_ov        = r_ov && !o_rsp.ready;
        n_o_matched = r_o_matched;
        n_o_zone    = r_o_zone;
        n_o_num     = r_o_num;
        n_o_last    = r_o_last;
        preset_we   = 1'b0;
        zone_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_key    = i_req.note_key;
                    n_vel    = i_req.note_velocity;
                    n_limit  = limit_in;
                    n_pend_v = 1'b0;
                    n_state  = ST_FINISH;
                    unique case (i_req.req_type)
                        kvz_pkg::REQ_PRESET: begin
                            preset_we = (i_req.entry_index < 10'(PRESET_COUNT));
                        end
                        kvz_pkg::REQ_ZONE: begin
                            zone_we = ({7'b0, i_req.entry_index} < 17'(ZONE_DEPTH));
                        end
                        kvz_pkg::REQ_LOOKUP: begin
                            if (lookup_ok) begin
                                n_state = ST_PRESET;
                            end
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_PRESET: begin
                n_zi    = {1'b0, preset_rdata.first_zone};
                n_left  = preset_rdata.zone_span;
                n_found = '0;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = walk_end ? ST_FINISH : ST_COMPARE;
            end
            ST_COMPARE: begin
                if (!hit || !r_pend_v || out_free) begin
                    if (hit) begin
                        if (r_pend_v) begin
                            n_ov        = 1'b1;
                            n_o_matched = 1'b1;
                            n_o_zone    = r_pend_zi;
                            n_o_num     = r_pend_num;
                            n_o_last    = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_zi  = r_zi[9:0];
                        n_pend_num = r_found[5:0];
                        n_found    = r_found + 7'd1;
                    end
                    n_zi    = r_zi + 11'd1;
                    n_left  = r_left - 11'd1;
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_ov        = 1'b1;
                    n_o_matched = r_pend_v;
                    n_o_zone    = r_pend_v ? r_pend_zi : '0;
                    n_o_num     = r_pend_v ? r_pend_num : '0;
                    n_o_last    = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_vel       <= n_vel;
        r_limit     <= n_limit;
        r_zi        <= n_zi;
        r_left      <= n_left;
        r_found     <= n_found;
        r_pend_zi   <= n_pend_zi;
        r_pend_num  <= n_pend_num;
        r_o_matched <= n_o_matched;
        r_o_zone    <= n_o_zone;
        r_o_num     <= n_o_num;
        r_o_last    <= n_o_last;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.matched      = r_o_matched;
    assign o_rsp.zone_index   = r_o_zone;
    assign o_rsp.match_number = r_o_num;
    assign o_rsp.last         = r_o_last;

endmodule

FILE: design/kvz_checker.sv
`timescale 1ns / 1ps

module kvz_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_rsp_matched,
    input logic [9:0] i_rsp_zone_index,
    input logic [5:0] i_rsp_match_number,
    input logic       i_rsp_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_zone_index) &&
                                        $stable(i_rsp_last) && $stable(i_rsp_matched))
        else $error("stalled result changed");

    a_unmatched_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_matched |-> i_rsp_last && (i_rsp_zone_index == '0) &&
                                          (i_rsp_match_number == '0))
        else $error("unmatched result not a lone final result");

    a_busy_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_last |-> !i_req_ready)
        else $error("request taken while lookup results remain");

endmodule

bind key_velocity_zone_lookup kvz_checker u_kvz_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_matched      (o_rsp.matched),
    .i_rsp_zone_index   (o_rsp.zone_index),
    .i_rsp_match_number (o_rsp.match_number),
    .i_rsp_last         (o_rsp.last)
);

FILE: dv/tb_key_velocity_zone_lookup.sv
`timescale 1ns / 1ps

module tb_key_velocity_zone_lookup;
    import kvz_pkg::*;

    localparam int PRESET_COUNT    = 256;
    localparam int ZONE_DEPTH      = 1024;
    localparam int MAX_MATCH_LIMIT = 64;
    localparam int IDLE_LIMIT      = 20000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 20;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 60;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  req_type;
        logic [9:0]  entry_index;
        logic [9:0]  first_zone;
        logic [10:0] zone_span;
        logic [6:0]  key_low;
        logic [6:0]  key_high;
        logic [6:0]  vel_low;
        logic [6:0]  vel_high;
        logic [13:0] bank_number;
        logic [7:0]  program_number;
        logic [6:0]  note_key;
        logic [6:0]  note_velocity;
    } t_request;

    typedef struct {
        logic       matched;
        logic [9:0] zone_index;
        logic [5:0] match_number;
        logic       last;
    } t_zone_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [10:0] i_cfg_wdata;

    kvz_req_if req_bus ();
    kvz_rsp_if rsp_bus ();

    key_velocity_zone_lookup #(
        .PRESET_COUNT    (PRESET_COUNT),
        .ZONE_DEPTH      (ZONE_DEPTH),
        .MAX_MATCH_LIMIT (MAX_MATCH_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    t_request     request_backlog[$];
    t_zone_result awaited_results[$];

    t_preset      shadow_preset [PRESET_COUNT];
    t_zone        shadow_zone [ZONE_DEPTH];
    logic [10:0]  zone_total_copy;
    logic [6:0]   max_matches_copy;

    t_preset      plan_preset [PRESET_COUNT];
    bit           plan_preset_set [PRESET_COUNT];
    bit           plan_zone_set [ZONE_DEPTH];
    int           plan_zone_total = 0;
    int           plan_slots[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int results_taken = 0;
    int hits_seen     = 0;
    int deepest_hit   = 0;
    int error_count   = 0;
    bit calm          = 1'b0;
    bit req_taken     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic void predict_zone_walk(t_request rq);
        t_zone_result held;
        t_preset      entry;
        t_zone        zn;
        int           limit;
        int           found;
        int           slot;
        int           zi;
        bit           stop;
        held  = '{1'b0, 10'd0, 6'd0, 1'b1};
        found = 0;
        case (rq.req_type)
            REQ_PRESET: begin
                if (rq.entry_index < PRESET_COUNT) begin
                    shadow_preset[rq.entry_index] = '{rq.zone_span, rq.first_zone};
                end
            end
            REQ_ZONE: begin
                if (rq.entry_index < ZONE_DEPTH) begin
                    shadow_zone[rq.entry_index] = '{rq.vel_high, rq.vel_low,
                                                    rq.key_high, rq.key_low};
                end
            end
            REQ_LOOKUP: begin
                limit = (max_matches_copy > MAX_MATCH_LIMIT) ? MAX_MATCH_LIMIT
                                                             : int'(max_matches_copy);
                if (zone_total_copy != 0 && rq.program_number <= PROG_MAX) begin
                    slot = (rq.bank_number == DRUM_BANK)
                         ? int'(DRUM_BANK) + int'(rq.program_number)
                         : int'(rq.program_number);
                    if (slot < PRESET_COUNT) begin
                        entry = shadow_preset[slot];
                        stop  = 1'b0;
                        for (int i = 0; i < entry.zone_span && !stop && found < limit; i++) begin
                            zi = entry.first_zone + i;
                            if (zi >= zone_total_copy || zi >= ZONE_DEPTH) begin
                                stop = 1'b1;
                            end else begin
                                zn = shadow_zone[zi];
                                if (rq.note_key >= zn.key_low && rq.note_key <= zn.key_high &&
                                    rq.note_velocity >= zn.vel_low &&
                                    rq.note_velocity <= zn.vel_high) begin
                                    if (found != 0) begin
                                        awaited_results.push_back(held);
                                    end
                                    held = '{1'b1, zi[9:0], found[5:0], 1'b0};
                                    found++;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        held.last = 1'b1;
        awaited_results.push_back(held);
    endfunction

    function automatic t_request noise_request();
        t_request rq;
        rq.req_type       = REQ_LOOKUP;
        rq.entry_index    = 10'($urandom_range(1023));
        rq.first_zone     = 10'($urandom_range(1023));
        rq.zone_span      = 11'($urandom_range(1024));
        rq.key_low        = 7'($urandom_range(127));
        rq.key_high       = 7'($urandom_range(127));
        rq.vel_low        = 7'($urandom_range(127));
        rq.vel_high       = 7'($urandom_range(127));
        rq.bank_number    = 14'($urandom_range(16383));
        rq.program_number = 8'($urandom_range(255));
        rq.note_key       = 7'($urandom_range(127));
        rq.note_velocity  = 7'($urandom_range(127));
        return rq;
    endfunction

    function automatic void enqueue(t_request rq);
        request_backlog.push_back(rq);
        items_queued++;
    endfunction

    function automatic void plan_preset_write(int slot, int first, int span);
        t_request rq;
        rq             = noise_request();
        rq.req_type    = REQ_PRESET;
        rq.entry_index = 10'(slot);
        rq.first_zone  = 10'(first);
        rq.zone_span   = 11'(span);
        if (slot < PRESET_COUNT) begin
            plan_preset[slot]     = '{rq.zone_span, rq.first_zone};
            plan_preset_set[slot] = 1'b1;
            plan_slots.push_back(slot);
        end
        enqueue(rq);
    endfunction

    function automatic void plan_zone_write(int slot, int kl, int kh, int vl, int vh);
        t_request rq;
        rq             = noise_request();
        rq.req_type    = REQ_ZONE;
        rq.entry_index = 10'(slot);
        rq.key_low     = 7'(kl);
        rq.key_high    = 7'(kh);
        rq.vel_low     = 7'(vl);
        rq.vel_high    = 7'(vh);
        plan_zone_set[slot] = 1'b1;
        enqueue(rq);
    endfunction

    // a lookup may only walk entries that were already written
    function automatic bit walk_is_written(int bank, int prog);
        t_preset entry;
        int      slot;
        int      zi;
        if (plan_zone_total == 0 || prog > PROG_MAX) begin
            return 1'b1;
        end
        slot = (bank == DRUM_BANK) ? DRUM_BANK + prog : prog;
        if (!plan_preset_set[slot]) begin
            return 1'b0;
        end
        entry = plan_preset[slot];
        for (int i = 0; i < entry.zone_span; i++) begin
            zi = entry.first_zone + i;
            if (zi >= plan_zone_total || zi >= ZONE_DEPTH) begin
                return 1'b1;
            end
            if (!plan_zone_set[zi]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void plan_lookup(int bank, int prog, int key, int vel);
        t_request rq;
        rq                = noise_request();
        rq.req_type       = REQ_LOOKUP;
        rq.bank_number    = 14'(bank);
        rq.program_number = walk_is_written(bank, prog) ? 8'(prog)
                                                        : 8'($urandom_range(255, 128));
        rq.note_key       = 7'(key);
        rq.note_velocity  = 7'(vel);
        enqueue(rq);
    endfunction

    function automatic void plan_stray(bit unused_type);
        t_request rq;
        rq = noise_request();
        if (unused_type) begin
            rq.req_type = REQ_UNUSED;
        end else begin
            rq.program_number = 8'($urandom_range(255, 128));
        end
        enqueue(rq);
    endfunction

    task automatic plan_random(int count);
        int pick;
        int slot;
        int first;
        int kl;
        int kh;
        int vl;
        int vh;
        int swap;
        int bank;
        int prog;
        bit ok;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                slot = ($urandom_range(99) < 85) ? $urandom_range(127)
                                                 : $urandom_range(ZONE_DEPTH - 1);
                kl = $urandom_range(127);
                kh = $urandom_range(127);
                vl = $urandom_range(127);
                vh = $urandom_range(127);
                if ($urandom_range(99) < 80) begin
                    if (kl > kh) begin
                        swap = kl;
                        kl   = kh;
                        kh   = swap;
                    end
                    if (vl > vh) begin
                        swap = vl;
                        vl   = vh;
                        vh   = swap;
                    end
                end
                plan_zone_write(slot, kl, kh, vl, vh);
            end else if (pick < 25) begin
                slot  = ($urandom_range(9) == 0) ? $urandom_range(1023, PRESET_COUNT)
                                                 : $urandom_range(PRESET_COUNT - 1);
                first = ($urandom_range(4) == 0) ? $urandom_range(ZONE_DEPTH - 1)
                                                 : $urandom_range(99);
                plan_preset_write(slot, first,
                                  ($urandom_range(9) == 0) ? $urandom_range(1024)
                                                           : $urandom_range(40));
            end else if (pick < 32) begin
                plan_stray($urandom_range(1));
            end else begin
                ok = 1'b0;
                for (int t = 0; t < 6 && !ok; t++) begin
                    slot = plan_slots[$urandom_range(plan_slots.size() - 1)];
                    if (slot > PROG_MAX) begin
                        bank = DRUM_BANK;
                        prog = slot - DRUM_BANK;
                    end else begin
                        bank = $urandom_range(16383);
                        if (bank == DRUM_BANK) begin
                            bank = 0;
                        end
                        prog = slot;
                    end
                    ok = walk_is_written(bank, prog);
                end
                plan_lookup(bank, prog, $urandom_range(127), $urandom_range(127));
            end
        end
    endtask

    task automatic write_register(logic index, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_ZONE_TOTAL) begin
            plan_zone_total = value;
        end
    endtask

    task automatic settle();
        while (items_taken != items_queued || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : driver
        t_request rq;
        if (i_rst_n && (!req_bus.valid || req_taken)) begin
            if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
                rq = request_backlog.pop_front();
                req_bus.req_type       <= rq.req_type;
                req_bus.entry_index    <= rq.entry_index;
                req_bus.first_zone     <= rq.first_zone;
                req_bus.zone_span      <= rq.zone_span;
                req_bus.key_low        <= rq.key_low;
                req_bus.key_high       <= rq.key_high;
                req_bus.vel_low        <= rq.vel_low;
                req_bus.vel_high       <= rq.vel_high;
                req_bus.bank_number    <= rq.bank_number;
                req_bus.program_number <= rq.program_number;
                req_bus.note_key       <= rq.note_key;
                req_bus.note_velocity  <= rq.note_velocity;
                req_bus.valid          <= 1'b1;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(negedge i_clk) begin : receiver
        int hold_left;
        bit hold_done;
        if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_request     rq;
        t_zone_result got;
        t_zone_result want;
        int           idle_cycles;
        if (!i_rst_n) begin
            req_taken        <= 1'b0;
            zone_total_copy  = '0;
            max_matches_copy = 7'd64;
            idle_cycles      = 0;
        end else begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ZONE_TOTAL) begin
                    zone_total_copy = i_cfg_wdata;
                end else begin
                    max_matches_copy = i_cfg_wdata[6:0];
                end
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{rsp_bus.matched, rsp_bus.zone_index, rsp_bus.match_number, rsp_bus.last};
                results_taken++;
                if (got.matched === 1'b1) begin
                    hits_seen++;
                    if (got.match_number > deepest_hit) begin
                        deepest_hit = int'(got.match_number);
                    end
                end
                if (awaited_results.size() == 0) begin
                    note_error($sformatf("result with nothing awaited: matched %0d zone %0d %s %0d last %0d",
                                         got.matched, got.zone_index, "number",
                                         got.match_number, got.last));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.matched !== want.matched || got.zone_index !== want.zone_index ||
                        got.match_number !== want.match_number || got.last !== want.last) begin
                        note_error($sformatf({"result %0d: expected matched %0d zone %0d ",
                                              "number %0d last %0d, got matched %0d zone %0d ",
                                              "number %0d last %0d"},
                                             results_taken, want.matched, want.zone_index,
                                             want.match_number, want.last, got.matched,
                                             got.zone_index, got.match_number, got.last));
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                rq.req_type       = req_bus.req_type;
                rq.entry_index    = req_bus.entry_index;
                rq.first_zone     = req_bus.first_zone;
                rq.zone_span      = req_bus.zone_span;
                rq.key_low        = req_bus.key_low;
                rq.key_high       = req_bus.key_high;
                rq.vel_low        = req_bus.vel_low;
                rq.vel_high       = req_bus.vel_high;
                rq.bank_number    = req_bus.bank_number;
                rq.program_number = req_bus.program_number;
                rq.note_key       = req_bus.note_key;
                rq.note_velocity  = req_bus.note_velocity;
                predict_zone_walk(rq);
                items_taken++;
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = CFG_ZONE_TOTAL;
        i_cfg_wdata            = '0;
        req_bus.valid          = 1'b0;
        req_bus.req_type       = REQ_PRESET;
        req_bus.entry_index    = '0;
        req_bus.first_zone     = '0;
        req_bus.zone_span      = '0;
        req_bus.key_low        = '0;
        req_bus.key_high       = '0;
        req_bus.vel_low        = '0;
        req_bus.vel_high       = '0;
        req_bus.bank_number    = '0;
        req_bus.program_number = '0;
        req_bus.note_key       = '0;
        req_bus.note_velocity  = '0;
        rsp_bus.ready          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan_lookup(0, 0, 64, 64);
        plan_stray(1'b1);
        plan_zone_write(0, 0, 127, 0, 127);
        plan_zone_write(1, 60, 60, 0, 127);
        plan_zone_write(2, 10, 5, 0, 127);
        plan_zone_write(3, 0, 127, 127, 127);
        plan_zone_write(ZONE_DEPTH - 1, 0, 127, 0, 127);
        plan_preset_write(0, 0, 4);
        plan_preset_write(DRUM_BANK + 5, 1, 1);
        plan_preset_write(PRESET_COUNT - 1, ZONE_DEPTH - 1, 1);
        plan_preset_write(1, 0, 0);
        plan_preset_write(2, ZONE_DEPTH - 1, ZONE_DEPTH);
        plan_preset_write(PRESET_COUNT, 0, 0);
        plan_preset_write(1023, 1023, 1024);
        settle();

        write_register(CFG_ZONE_TOTAL, ZONE_DEPTH);
        plan_lookup(0, 0, 60, 127);
        plan_lookup(0, 0, 61, 50);
        plan_lookup(DRUM_BANK, 5, 60, 0);
        plan_lookup(DRUM_BANK, 5, 0, 0);
        plan_lookup(DRUM_BANK, PROG_MAX, 0, 0);
        plan_lookup(0, 1, 60, 60);
        plan_lookup(0, 2, 7, 7);
        plan_lookup(0, 200, 60, 60);
        plan_lookup(16383, 0, 127, 127);
        plan_lookup(DRUM_BANK - 1, 0, 0, 127);
        plan_lookup(DRUM_BANK + 1, 0, 127, 0);
        plan_lookup(0, PROG_MAX + 1, 60, 60);
        settle();

        write_register(CFG_ZONE_TOTAL, 68);
        write_register(CFG_MAX_MATCHES, 127);
        for (int z = 4; z < 68; z++) begin
            plan_zone_write(z, 0, 127, 0, 127);
        end
        plan_preset_write(10, 0, 68);
        plan_preset_write(11, 0, ZONE_DEPTH);
        plan_lookup(5, 10, 60, 127);
        plan_lookup(0, 11, 0, 0);
        plan_random(40);
        settle();

        write_register(CFG_MAX_MATCHES, 0);
        plan_lookup(0, 10, 60, 127);
        plan_random(10);
        settle();

        write_register(CFG_MAX_MATCHES, 1);
        plan_lookup(0, 0, 60, 127);
        plan_random(15);
        settle();

        write_register(CFG_ZONE_TOTAL, 40);
        write_register(CFG_MAX_MATCHES, 5);
        plan_random(25);
        settle();

        write_register(CFG_ZONE_TOTAL, ZONE_DEPTH);
        write_register(CFG_MAX_MATCHES, MAX_MATCH_LIMIT);
        calm = 1'b1;
        plan_random(30);
        settle();
        calm = 1'b0;

        write_register(CFG_ZONE_TOTAL, 0);
        plan_random(5);
        settle();

        write_register(CFG_ZONE_TOTAL, 1);
        write_register(CFG_MAX_MATCHES, 2);
        plan_random(10);
        settle();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (awaited_results.size() != 0) begin
            note_error($sformatf("%0d results never arrived", awaited_results.size()));
        end
        $display("run: %0d requests taken, %0d results checked, %0d zone hits, top match number %0d",
                 items_taken, results_taken, hits_seen, deepest_hit);
        $display("run: zone_total 0/1/40/68/1024 and max_matches 0/1/2/5/64/127 exercised");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
